// ----- sv/cbp_pkg.sv -----
// Package with the sizes, counter codes and update functions of the correlating branch predictor.
package cbp_pkg;

    localparam int PC_INDEX_BITS = 10;
    localparam int HISTORY_BITS  = 2;

    localparam int TABLE_BITS  = PC_INDEX_BITS + HISTORY_BITS;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;
    localparam int IDX_W       = (TABLE_BITS > 0) ? TABLE_BITS : 1;
    localparam int HIST_W      = (HISTORY_BITS > 0) ? HISTORY_BITS : 1;

    typedef logic [1:0]        counter_t;
    typedef logic [IDX_W-1:0]  index_t;
    typedef logic [HIST_W-1:0] history_t;

    localparam counter_t CNT_STRONG_NT = 2'b00;
    localparam counter_t CNT_WEAK_NT   = 2'b01;
    localparam counter_t CNT_WEAK_T    = 2'b10;
    localparam counter_t CNT_STRONG_T  = 2'b11;

    localparam logic [63:0] PC_MASK      = (64'd1 << PC_INDEX_BITS) - 64'd1;
    localparam history_t    HIST_RESET   = (HISTORY_BITS > 0) ? '1 : '0;

    function automatic counter_t next_counter(counter_t cnt, logic outcome);
        counter_t result;
        if (outcome)
        begin
            result = (cnt == CNT_STRONG_NT) ? CNT_WEAK_NT : CNT_STRONG_T;
        end
        else
        begin
            result = (cnt == CNT_STRONG_T) ? CNT_WEAK_T : CNT_STRONG_NT;
        end
        return result;
    endfunction

    function automatic history_t next_history(history_t hist, logic outcome);
        history_t result;
        if (HISTORY_BITS == 0)
        begin
            result = '0;
        end
        else
        begin
            result = (hist >> 1) | (history_t'(outcome) << (HIST_W - 1));
        end
        return result;
    endfunction

    function automatic index_t table_index(history_t hist, logic [31:0] pc);
        logic [63:0] wide;
        logic [63:0] hist_part;
        hist_part = (HISTORY_BITS > 0) ? 64'(hist) : 64'd0;
        wide = (hist_part << PC_INDEX_BITS) | (64'(pc) & PC_MASK);
        return wide[IDX_W-1:0];
    endfunction

endpackage

// ----- sv/correlating_branch_predictor.sv -----
// Top level of the correlating branch predictor with 2-bit jump counters.
// After reset the block steps through all 4096 table entries, setting every counter to
// strongly taken, and takes no branch until that pass ends. For each branch the counter
// table memory is read in the cycle the transaction is accepted, and the prediction is
// formed and the updated counter written back in the next one, with the previous write
// forwarded when two consecutive branches hit the same entry. A new branch can be accepted
// every cycle as long as predictions are taken; a two-entry output queue absorbs stalls on
// the prediction channel.
module correlating_branch_predictor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        branch_valid,
    output logic        branch_ready,
    input  logic [31:0] branch_pc,
    input  logic        taken,
    output logic        predict_valid,
    input  logic        predict_ready,
    output logic        predicted_taken
);

    logic                clear_done_reg;
    logic                clear_done_next;
    cbp_pkg::index_t     clear_idx_reg;
    cbp_pkg::index_t     clear_idx_next;

    cbp_pkg::history_t   history_reg;
    cbp_pkg::history_t   history_next;

    logic                s1_valid_reg;
    cbp_pkg::index_t     s1_idx_reg;
    logic                s1_taken_reg;

    logic                lw_valid_reg;
    cbp_pkg::index_t     lw_idx_reg;
    cbp_pkg::counter_t   lw_data_reg;

    logic                fifo_data_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          fifo_cnt_reg;
    logic [1:0]          fifo_cnt_next;

    logic                accept;
    logic                pop;
    logic [2:0]          occupancy;
    cbp_pkg::index_t     rd_idx;
    cbp_pkg::counter_t   ram_rdata;
    cbp_pkg::counter_t   cur_cnt;
    cbp_pkg::counter_t   new_cnt;
    logic                ram_we;
    cbp_pkg::index_t     ram_waddr;
    cbp_pkg::counter_t   ram_wdata;

    assign pop       = predict_valid && predict_ready;
    assign occupancy = {1'b0, fifo_cnt_reg} + {2'b00, s1_valid_reg};
    assign branch_ready = clear_done_reg &&
                          ((occupancy < 3'd2) || ((occupancy == 3'd2) && pop));
    assign accept    = branch_valid && branch_ready;

    assign rd_idx = cbp_pkg::table_index(history_reg, branch_pc);

    always_comb
    begin
        cur_cnt = ram_rdata;
        if (lw_valid_reg && (lw_idx_reg == s1_idx_reg))
        begin
            cur_cnt = lw_data_reg;
        end
        new_cnt = cbp_pkg::next_counter(cur_cnt, s1_taken_reg);
    end

    always_comb
    begin
        if (!clear_done_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clear_idx_reg;
            ram_wdata = cbp_pkg::CNT_STRONG_T;
        end
        else
        begin
            ram_we    = s1_valid_reg;
            ram_waddr = s1_idx_reg;
            ram_wdata = new_cnt;
        end
    end

    cbp_ram #(
        .WIDTH(2),
        .DEPTH(cbp_pkg::TABLE_DEPTH)
    ) u_counter_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(rd_idx),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        clear_idx_next  = clear_idx_reg;
        clear_done_next = clear_done_reg;
        if (!clear_done_reg)
        begin
            clear_idx_next = clear_idx_reg + cbp_pkg::index_t'(1);
            if (clear_idx_reg == cbp_pkg::index_t'(cbp_pkg::TABLE_DEPTH - 1))
            begin
                clear_done_next = 1'b1;
            end
        end
    end

    assign history_next = accept ? cbp_pkg::next_history(history_reg, taken) : history_reg;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (s1_valid_reg && !pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + 2'd1;
        end
        else if (!s1_valid_reg && pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_done_reg <= 1'b0;
            clear_idx_reg  <= '0;
            history_reg    <= cbp_pkg::HIST_RESET;
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            fifo_cnt_reg   <= 2'd0;
        end
        else
        begin
            clear_done_reg <= clear_done_next;
            clear_idx_reg  <= clear_idx_next;
            history_reg    <= history_next;
            s1_valid_reg   <= accept;
            lw_valid_reg   <= s1_valid_reg;
            fifo_cnt_reg   <= fifo_cnt_next;
            if (s1_valid_reg)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= rd_idx;
            s1_taken_reg <= taken;
        end
        if (s1_valid_reg)
        begin
            lw_idx_reg                <= s1_idx_reg;
            lw_data_reg               <= new_cnt;
            fifo_data_reg[wr_ptr_reg] <= cur_cnt[1];
        end
    end

    assign predict_valid   = (fifo_cnt_reg != 2'd0);
    assign predicted_taken = fifo_data_reg[rd_ptr_reg];

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= 2'd2)
        else $error("Prediction queue holds more than two entries.");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_done_reg |-> !branch_ready)
        else $error("Branch accepted during the table clearing pass.");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !pop) |-> (fifo_cnt_reg < 2'd2))
        else $error("Prediction pushed into a full queue.");

    a_forward_source: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> lw_valid_reg && (lw_idx_reg == $past(s1_idx_reg)))
        else $error("Forwarding register does not track the last table write.");

endmodule

// ----- sv/cbp_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module cbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- tb/sv/tb_correlating_branch_predictor.sv -----
// Self-checking testbench for the correlating branch predictor with 2-bit jump counters.
module tb_correlating_branch_predictor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BRANCHES = 500;
    localparam int HOT_SITES = 8;

    typedef struct {
        logic [31:0] pc;
        logic        outcome;
        bit          drain;
    } branch_t;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_EVERY_FOURTH, READY_SPARSE} ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        branch_valid = 1'b0;
    logic        branch_ready;
    logic [31:0] branch_pc = '0;
    logic        taken = 1'b0;
    logic        predict_valid;
    logic        predict_ready = 1'b0;
    logic        predicted_taken;

    cbp_pkg::counter_t pattern_table [cbp_pkg::TABLE_DEPTH];
    int unsigned       branch_history;

    branch_t     branch_queue[$];
    logic        predictions_due[$];

    int          errors = 0;
    int          branches_sent = 0;
    int          predictions_checked = 0;
    int          mispredicts = 0;
    int          cycle_count = 0;
    int          idle_left = 0;
    int          burst_left = 0;
    int          mode_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;

    logic [31:0] hot_pc [HOT_SITES];
    int unsigned hot_bias [HOT_SITES];

    correlating_branch_predictor dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .branch_valid   (branch_valid),
        .branch_ready   (branch_ready),
        .branch_pc      (branch_pc),
        .taken          (taken),
        .predict_valid  (predict_valid),
        .predict_ready  (predict_ready),
        .predicted_taken(predicted_taken)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic resolve_branch(logic [31:0] pc, logic outcome);
        longint unsigned   column;
        longint unsigned   entry;
        cbp_pkg::counter_t state;
        cbp_pkg::counter_t updated;
        logic              guess;
        column = longint'(pc) & ((64'd1 << cbp_pkg::PC_INDEX_BITS) - 64'd1);
        entry = column;
        if (cbp_pkg::HISTORY_BITS > 0)
        begin
            entry = (longint'(branch_history) << cbp_pkg::PC_INDEX_BITS) | column;
        end
        state = pattern_table[entry];
        guess = state[1];
        case (state)
            cbp_pkg::CNT_STRONG_NT:
                updated = outcome ? cbp_pkg::CNT_WEAK_NT : cbp_pkg::CNT_STRONG_NT;
            cbp_pkg::CNT_STRONG_T:
                updated = outcome ? cbp_pkg::CNT_STRONG_T : cbp_pkg::CNT_WEAK_T;
            default:
                updated = outcome ? cbp_pkg::CNT_STRONG_T : cbp_pkg::CNT_STRONG_NT;
        endcase
        pattern_table[entry] = updated;
        if (cbp_pkg::HISTORY_BITS > 0)
        begin
            branch_history = (branch_history >> 1)
                             | (int'(outcome) << (cbp_pkg::HISTORY_BITS - 1));
        end
        return guess;
    endfunction

    function automatic void add_branch(logic [31:0] pc, logic outcome, bit drain);
        branch_t b;
        b.pc = pc;
        b.outcome = outcome;
        b.drain = drain;
        branch_queue.push_back(b);
    endfunction

    always @(posedge clk)
    begin
        branch_t next_branch;
        logic    drive_valid;
        if (rst_n)
        begin
            if (branch_valid && branch_ready)
            begin
                predictions_due.push_back(resolve_branch(branch_pc, taken));
                branches_sent++;
            end
            if (!branch_valid || branch_ready)
            begin
                drive_valid = 1'b0;
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (branch_queue.size() > 0 &&
                         !(branch_queue[0].drain && predictions_due.size() > 0))
                begin
                    next_branch = branch_queue.pop_front();
                    branch_pc <= next_branch.pc;
                    taken <= next_branch.outcome;
                    drive_valid = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else if ($urandom_range(0, 4) == 0)
                    begin
                        idle_left = 0;
                        burst_left = $urandom_range(40, 90);
                    end
                    else
                    begin
                        idle_left = $urandom_range(1, 8);
                        burst_left = $urandom_range(0, 20);
                    end
                end
                branch_valid <= drive_valid;
            end
        end
    end

    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (predict_valid && predict_ready)
            begin
                predictions_checked++;
                if (predictions_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected prediction, expected none, actual %0b",
                             $realtime, predicted_taken);
                end
                else
                begin
                    want = predictions_due.pop_front();
                    if (predicted_taken !== want)
                    begin
                        errors++;
                        $display("%0t: predicted_taken mismatch, expected %0b, actual %0b",
                                 $realtime, want, predicted_taken);
                    end
                end
            end
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            else
            begin
                mode_left--;
            end
            case (ready_mode)
                READY_ALWAYS:       predict_ready <= 1'b1;
                READY_COIN:         predict_ready <= 1'($urandom_range(0, 1));
                READY_EVERY_FOURTH: predict_ready <= (cycle_count % 4 == 0);
                default:            predict_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t: timeout with %0d predictions outstanding",
                 $realtime, predictions_due.size());
        $display("** correlating_branch_predictor: FAILED **");
        $finish;
    end

    initial
    begin
        int          site;
        logic [31:0] pc;
        for (int i = 0; i < cbp_pkg::TABLE_DEPTH; i++)
        begin
            pattern_table[i] = cbp_pkg::CNT_STRONG_T;
        end
        branch_history = (1 << cbp_pkg::HISTORY_BITS) - 1;

        add_branch(32'h0000_0000, 1'b1, 1'b0);
        add_branch(32'h0000_0000, 1'b1, 1'b0);
        add_branch(32'h0000_0000, 1'b0, 1'b0);
        add_branch(32'h0000_0000, 1'b0, 1'b0);
        add_branch(32'h0000_0000, 1'b0, 1'b0);
        add_branch(32'h0000_0000, 1'b1, 1'b0);
        add_branch(32'h0000_0000, 1'b1, 1'b0);
        add_branch(32'h0000_0400, 1'b1, 1'b0);
        add_branch(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_branch(32'hFFFF_FFFF, 1'b0, 1'b0);
        add_branch(32'hFFFF_FC00, 1'b1, 1'b0);
        add_branch(32'h0000_03FF, 1'b1, 1'b0);
        add_branch(32'h0000_03FF, 1'b0, 1'b0);
        add_branch(32'h0000_03FF, 1'b1, 1'b0);
        add_branch(32'h8000_0000, 1'b0, 1'b0);
        add_branch(32'h5555_5555, 1'b1, 1'b0);
        add_branch(32'hAAAA_AAAA, 1'b0, 1'b0);
        add_branch(32'h0000_0000, 1'b0, 1'b0);
        add_branch(32'h0000_0000, 1'b1, 1'b1);
        add_branch(32'h0000_0000, 1'b1, 1'b0);
        add_branch(32'hFFFF_FFFF, 1'b1, 1'b0);

        hot_pc[0] = 32'h0000_0000;
        hot_pc[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < HOT_SITES; i++)
        begin
            hot_pc[i] = $urandom;
        end
        for (int i = 0; i < HOT_SITES; i++)
        begin
            hot_bias[i] = $urandom_range(0, 100);
        end

        for (int i = 0; i < RANDOM_BRANCHES; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                add_branch($urandom, 1'($urandom_range(0, 1)), (i % 200) == 199);
            end
            else
            begin
                site = $urandom_range(0, HOT_SITES - 1);
                pc = $urandom;
                pc = (pc & ~32'((64'd1 << cbp_pkg::PC_INDEX_BITS) - 64'd1))
                     | (hot_pc[site] & 32'((64'd1 << cbp_pkg::PC_INDEX_BITS) - 64'd1));
                add_branch(pc, $urandom_range(1, 100) <= hot_bias[site], (i % 200) == 199);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (branch_queue.size() > 0 || branch_valid)
        begin
            @(negedge clk);
        end
        while (predictions_due.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Resolved %0d branches over hot and random addresses, %0d predictions checked.",
                 branches_sent, predictions_checked);
        if (errors == 0)
        begin
            $display("** correlating_branch_predictor: PASSED **");
        end
        else
        begin
            $display("** correlating_branch_predictor: FAILED **");
        end
        $finish;
    end

endmodule
